[design/bearing_range_offset_defines.svh]
// Assertion macros shared by the checker of the bearing and range offset block.
`ifndef BEARING_RANGE_OFFSET_DEFINES_SVH
`define BEARING_RANGE_OFFSET_DEFINES_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define BRO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define BRO_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

[design/bro_pkg.sv]
// Types and constants shared by the bearing and range offset pipeline.
package bro_pkg;

    localparam int XW     = 46;       // CORDIC vector width, millimetres in Q16
    localparam int ZW     = 33;       // CORDIC angle width, Q30 radians
    localparam int LEG_W  = XW - 16;  // rounded leg width
    localparam int OFS_W  = LEG_W + 1;
    localparam int MAG_W  = 28;
    localparam int RES_W  = 17;       // residual angle below a quarter turn
    localparam int BRG_W  = 19;       // wrapped bearing below a full turn
    localparam int REM_W  = 20;       // remainder before the final correction
    localparam int QUO_W  = 14;

    localparam logic [QUO_W-1:0] RECIP_TURN   = 14'd11930;    // floor(2^32 / 360000)
    localparam logic [18:0]      FULL_TURN    = 19'd360000;
    localparam logic [16:0]      QUARTER      = 17'd90000;
    localparam logic [17:0]      HALF         = 18'd180000;
    localparam logic [18:0]      THREE_QUART  = 19'd270000;
    localparam logic [16:0]      BIAS_REM     = 17'd83648;    // 2^31 mod 360000
    localparam logic [30:0]      MDEG_TO_Q30  = 31'd1228166276;
    localparam logic [31:0]      INV_GAIN_Q32 = 32'd2608131497;
    localparam logic [XW-1:0]    ROUND_HALF   = 46'd32768;

    localparam logic signed [33:0] EAST_LIM  = 34'sd2000000000;
    localparam logic signed [36:0] NORTH_LIM = 37'sd20000000000;

    localparam logic [30:0] ATAN_Q30 [0:31] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
        31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
        31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
        31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

    // Data that rides along with each word through the pipeline.
    typedef struct packed {
        logic signed [31:0] easting;
        logic signed [35:0] northing;
        logic [5:0]         zone;
        logic [1:0]         quad;
        logic               rzero;
        logic               rneg;
    } side_t;

endpackage

[design/bearing_range_offset.sv]
// Throughput: one word per cycle; busy stays low, so start may be held every cycle.
// Stages: four wrap stages, the CORDIC entry stage, one per rotation and three output stages.
// Results appear for one cycle with done high; the receiver cannot stall the pipeline.
// Reset clears every valid bit at once; words in flight are dropped.
module bearing_range_offset
    import bro_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  easting_mm,
    input  logic signed [35:0]  northing_mm,
    input  logic [5:0]          zone,
    input  logic signed [27:0]  range_mm,
    input  logic signed [31:0]  bearing_mdeg,
    output logic                done,
    output logic signed [31:0]  out_easting_mm,
    output logic signed [35:0]  out_northing_mm,
    output logic [5:0]          out_zone,
    output logic                saturated
);

    logic                  wrap_valid;
    side_t                 wrap_side;
    logic [RES_W-1:0]      wrap_resid;
    logic [MAG_W-1:0]      wrap_mag;
    logic                  rot_valid;
    side_t                 rot_side;
    logic signed [XW-1:0]  rot_x;
    logic signed [XW-1:0]  rot_y;

    assign busy = 1'b0;

    bro_wrap u_wrap (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start & ~busy),
        .easting_mm   (easting_mm),
        .northing_mm  (northing_mm),
        .zone         (zone),
        .range_mm     (range_mm),
        .bearing_mdeg (bearing_mdeg),
        .out_valid    (wrap_valid),
        .out_side     (wrap_side),
        .out_resid    (wrap_resid),
        .out_mag      (wrap_mag)
    );

    bro_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wrap_valid),
        .in_side   (wrap_side),
        .in_resid  (wrap_resid),
        .in_mag    (wrap_mag),
        .out_valid (rot_valid),
        .out_side  (rot_side),
        .out_x     (rot_x),
        .out_y     (rot_y)
    );

    bro_post u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (rot_valid),
        .in_side         (rot_side),
        .in_x            (rot_x),
        .in_y            (rot_y),
        .done            (done),
        .out_easting_mm  (out_easting_mm),
        .out_northing_mm (out_northing_mm),
        .out_zone        (out_zone),
        .saturated       (saturated)
    );

endmodule

[design/bro_wrap.sv]
// Bearing wrap: reduces the bearing modulo a full turn and splits off the quadrant.
module bro_wrap
    import bro_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  easting_mm,
    input  logic signed [35:0]  northing_mm,
    input  logic [5:0]          zone,
    input  logic signed [27:0]  range_mm,
    input  logic signed [31:0]  bearing_mdeg,
    output logic                out_valid,
    output side_t               out_side,
    output logic [RES_W-1:0]    out_resid,
    output logic [MAG_W-1:0]    out_mag
);

    logic [31:0]        biased;
    logic [45:0]        quo_prod;
    logic [32:0]        turn_prod;
    logic [32:0]        rem_full;
    logic signed [21:0] shifted;
    logic signed [21:0] wrap_up;
    logic signed [21:0] wrap_down;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    side_t              side1_reg, side2_reg, side3_reg, side4_reg, side4_next;
    logic [MAG_W-1:0]   mag1_reg, mag2_reg, mag3_reg, mag4_reg, mag1_next;
    logic [31:0]        u1_reg;
    logic [QUO_W-1:0]   q1_reg;
    logic [REM_W-1:0]   rem2_reg;
    logic [BRG_W-1:0]   b3_reg, b3_next;
    logic [RES_W-1:0]   resid4_reg, resid4_next;

    // Adding 2^31 makes the bearing unsigned; the bias is taken back out after the reduction.
    assign biased   = {~bearing_mdeg[31], bearing_mdeg[30:0]};
    assign quo_prod = 46'(biased) * 46'(RECIP_TURN);
    assign mag1_next = range_mm[27] ? MAG_W'(-range_mm) : MAG_W'(range_mm);

    // The quotient estimate is low by at most one, so the remainder stays below two turns.
    assign turn_prod = 33'(q1_reg) * 33'(FULL_TURN);
    assign rem_full  = 33'(u1_reg) - turn_prod;

    assign shifted   = $signed({2'b00, rem2_reg}) - $signed({5'b00000, BIAS_REM});
    assign wrap_up   = shifted + $signed({3'b000, FULL_TURN});
    assign wrap_down = shifted - $signed({3'b000, FULL_TURN});

    always_comb
    begin
        priority if (shifted[21])
        begin
            b3_next = wrap_up[BRG_W-1:0];
        end
        else if (shifted >= $signed({3'b000, FULL_TURN}))
        begin
            b3_next = wrap_down[BRG_W-1:0];
        end
        else
        begin
            b3_next = shifted[BRG_W-1:0];
        end
    end

    always_comb
    begin
        side4_next = side3_reg;
        priority if (b3_reg >= THREE_QUART)
        begin
            side4_next.quad = 2'd3;
            resid4_next     = RES_W'(b3_reg - THREE_QUART);
        end
        else if (b3_reg >= BRG_W'(HALF))
        begin
            side4_next.quad = 2'd2;
            resid4_next     = RES_W'(b3_reg - BRG_W'(HALF));
        end
        else if (b3_reg >= BRG_W'(QUARTER))
        begin
            side4_next.quad = 2'd1;
            resid4_next     = RES_W'(b3_reg - BRG_W'(QUARTER));
        end
        else
        begin
            side4_next.quad = 2'd0;
            resid4_next     = b3_reg[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg.easting  <= easting_mm;
        side1_reg.northing <= northing_mm;
        side1_reg.zone     <= zone;
        side1_reg.quad     <= 2'd0;
        side1_reg.rzero    <= (range_mm == 28'sd0);
        side1_reg.rneg     <= range_mm[27];
        mag1_reg   <= mag1_next;
        u1_reg     <= biased;
        q1_reg     <= quo_prod[45:32];

        side2_reg  <= side1_reg;
        mag2_reg   <= mag1_reg;
        rem2_reg   <= rem_full[REM_W-1:0];

        side3_reg  <= side2_reg;
        mag3_reg   <= mag2_reg;
        b3_reg     <= b3_next;

        side4_reg  <= side4_next;
        mag4_reg   <= mag3_reg;
        resid4_reg <= resid4_next;
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_resid = resid4_reg;
    assign out_mag   = mag4_reg;

endmodule

[design/bro_cordic.sv]
// Pipelined CORDIC rotator: one rotation stage per register.
module bro_cordic
    import bro_pkg::*;
#(
    parameter int STAGES = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  side_t                 in_side,
    input  logic [RES_W-1:0]      in_resid,
    input  logic [MAG_W-1:0]      in_mag,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic signed [XW-1:0]  out_x,
    output logic signed [XW-1:0]  out_y
);

    logic [47:0]           z_prod;
    logic [59:0]           x_prod;

    logic                  v_reg    [0:STAGES];
    side_t                 side_reg [0:STAGES];
    logic signed [XW-1:0]  x_reg    [0:STAGES];
    logic signed [XW-1:0]  y_reg    [0:STAGES];
    logic signed [ZW-1:0]  z_reg    [0:STAGES];

    assign z_prod = 48'(in_resid) * 48'(MDEG_TO_Q30);
    assign x_prod = 60'(in_mag) * 60'(INV_GAIN_Q32);

    // Entry stage: residual angle to Q30 radians, range scaled by the inverse gain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        z_reg[0]    <= $signed({1'b0, z_prod[47:16]});
        x_reg[0]    <= $signed({2'b00, x_prod[59:16]});
        y_reg[0]    <= '0;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_Q30[i]);

        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[i+1] <= side_reg[i];
            if (z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN_I;
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_side  = side_reg[STAGES];
    assign out_x     = x_reg[STAGES];
    assign out_y     = y_reg[STAGES];

endmodule

[design/bro_post.sv]
// Output stages: leg rounding, quadrant mapping, offset addition and saturation.
module bro_post
    import bro_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  side_t                 in_side,
    input  logic signed [XW-1:0]  in_x,
    input  logic signed [XW-1:0]  in_y,
    output logic                  done,
    output logic signed [31:0]    out_easting_mm,
    output logic signed [35:0]    out_northing_mm,
    output logic [5:0]            out_zone,
    output logic                  saturated
);

    logic signed [XW-1:0]     x_round;
    logic signed [XW-1:0]     y_round;
    logic signed [OFS_W-1:0]  e_leg;
    logic signed [OFS_W-1:0]  n_leg;
    logic                     e_neg;
    logic                     n_neg;
    logic signed [33:0]       sum_e;
    logic signed [36:0]       sum_n;
    logic                     e_hit;
    logic                     n_hit;

    logic                     v1_reg, v2_reg, done_reg;
    side_t                    side1_reg, side2_reg;
    logic signed [LEG_W-1:0]  c1_reg, s1_reg;
    logic signed [OFS_W-1:0]  de2_reg, dn2_reg, de2_next, dn2_next;
    logic signed [31:0]       east_reg, east_next;
    logic signed [35:0]       north_reg, north_next;
    logic [5:0]               zone_reg;
    logic                     sat_reg;

    assign x_round = in_x + $signed(ROUND_HALF);
    assign y_round = in_y + $signed(ROUND_HALF);

    // Odd quadrants swap the legs; the sign comes from the quadrant and the range sign.
    assign e_leg = side1_reg.quad[0] ? OFS_W'(c1_reg) : OFS_W'(s1_reg);
    assign n_leg = side1_reg.quad[0] ? OFS_W'(s1_reg) : OFS_W'(c1_reg);
    assign e_neg = side1_reg.quad[1] ^ side1_reg.rneg;
    assign n_neg = side1_reg.quad[1] ^ side1_reg.quad[0] ^ side1_reg.rneg;

    always_comb
    begin
        if (side1_reg.rzero)
        begin
            de2_next = '0;
            dn2_next = '0;
        end
        else
        begin
            de2_next = e_neg ? -e_leg : e_leg;
            dn2_next = n_neg ? -n_leg : n_leg;
        end
    end

    assign sum_e = 34'(side2_reg.easting) + 34'(de2_reg);
    assign sum_n = 37'(side2_reg.northing) + 37'(dn2_reg);

    always_comb
    begin
        e_hit = 1'b1;
        priority if (sum_e > EAST_LIM)
        begin
            east_next = EAST_LIM[31:0];
        end
        else if (sum_e < -EAST_LIM)
        begin
            east_next = 32'(-EAST_LIM);
        end
        else
        begin
            east_next = sum_e[31:0];
            e_hit     = 1'b0;
        end
    end

    always_comb
    begin
        n_hit = 1'b1;
        priority if (sum_n > NORTH_LIM)
        begin
            north_next = NORTH_LIM[35:0];
        end
        else if (sum_n < -NORTH_LIM)
        begin
            north_next = 36'(-NORTH_LIM);
        end
        else
        begin
            north_next = sum_n[35:0];
            n_hit      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= in_side;
        c1_reg    <= x_round[XW-1:16];
        s1_reg    <= y_round[XW-1:16];

        side2_reg <= side1_reg;
        de2_reg   <= de2_next;
        dn2_reg   <= dn2_next;

        east_reg  <= east_next;
        north_reg <= north_next;
        zone_reg  <= side2_reg.zone;
        sat_reg   <= e_hit | n_hit;
    end

    assign done            = done_reg;
    assign out_easting_mm  = east_reg;
    assign out_northing_mm = north_reg;
    assign out_zone        = zone_reg;
    assign saturated       = sat_reg;

endmodule

[design/bro_checker.sv]
// Port-level checker for the bearing and range offset block, with its bind.
`include "bearing_range_offset_defines.svh"

module bro_checker #(
    parameter int LATENCY = 32
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [5:0]          zone,
    input logic [5:0]          out_zone,
    input logic signed [31:0]  out_easting_mm,
    input logic signed [35:0]  out_northing_mm,
    input logic                saturated
);

    // Every accepted word comes out a fixed number of cycles later, and nothing else does.
    `BRO_ASSERT_DELAY(a_word_out, start && !busy, LATENCY, done, "accepted word not delivered")
    `BRO_ASSERT_IMPL(a_no_phantom, done, $past(start && !busy, LATENCY), "result without a word")
    `BRO_ASSERT_IMPL(a_zone_kept, done, out_zone == $past(zone, LATENCY), "zone not passed through")
    // A clipped result must sit on one of the coordinate limits.
    `BRO_ASSERT_IMPL(a_sat_limit, done && saturated,
        out_easting_mm == 32'sd2000000000 || out_easting_mm == -32'sd2000000000 ||
        out_northing_mm == 36'sd20000000000 || out_northing_mm == -36'sd20000000000,
        "saturated flag without a clipped coordinate")

endmodule

bind bearing_range_offset bro_checker #(
    .LATENCY (CORDIC_STAGES + 8)
) u_bro_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .zone            (zone),
    .out_zone        (out_zone),
    .out_easting_mm  (out_easting_mm),
    .out_northing_mm (out_northing_mm),
    .saturated       (saturated)
);

[verif/testbench.sv]
// Self-checking testbench for the bearing and range offset pipeline.
`timescale 1ns / 100ps

module testbench;

    localparam int     STAGES      = 24;
    localparam int     TAIL_CYCLES = STAGES + 16;
    localparam longint CYCLE_LIMIT = 300000;

    localparam longint TURN_MDEG    = 360000;
    localparam longint QUARTER_MDEG = 90000;
    localparam longint MDEG_Q30     = 64'd1228166276;
    localparam longint GAIN_INV_Q32 = 64'd2608131497;
    localparam longint EAST_MAX     = 64'd2000000000;
    localparam longint NORTH_MAX    = 64'd20000000000;
    localparam longint RANGE_MAX    = 64'd134217727;
    localparam longint RANGE_MIN    = -64'sd134217728;

    localparam longint ARCTAN_Q30 [0:31] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [31:0] east;
        logic signed [35:0] north;
        logic [5:0]         zone;
        logic               clipped;
    } grid_point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] easting_mm = '0;
    logic signed [35:0] northing_mm = '0;
    logic [5:0]         zone = '0;
    logic signed [27:0] range_mm = '0;
    logic signed [31:0] bearing_mdeg = '0;
    logic               done;
    logic signed [31:0] out_easting_mm;
    logic signed [35:0] out_northing_mm;
    logic [5:0]         out_zone;
    logic               saturated;

    grid_point_t pending_points [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          idle_on = 1'b1;

    bearing_range_offset #(.CORDIC_STAGES(STAGES)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .easting_mm      (easting_mm),
        .northing_mm     (northing_mm),
        .zone            (zone),
        .range_mm        (range_mm),
        .bearing_mdeg    (bearing_mdeg),
        .done            (done),
        .out_easting_mm  (out_easting_mm),
        .out_northing_mm (out_northing_mm),
        .out_zone        (out_zone),
        .saturated       (saturated)
    );

    always #5 clk = ~clk;

    // Moves the point along the bearing by a fixed-point CORDIC rotation.
    function automatic grid_point_t offset_point(longint e, longint n, logic [5:0] zn,
                                                 longint rng, longint brg);
        grid_point_t p;
        longint de, dn, b, q, r, mag, x, y, z, c, s, xs, ys, east, north;
        de = 0;
        dn = 0;
        p.clipped = 1'b0;
        if (rng != 0)
        begin
            b = brg % TURN_MDEG;
            if (b < 0)
                b += TURN_MDEG;
            q = b / QUARTER_MDEG;
            r = b % QUARTER_MDEG;
            mag = (rng < 0) ? -rng : rng;
            z = (r * MDEG_Q30) >>> 16;
            x = (mag * GAIN_INV_Q32) >>> 16;
            y = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= ARCTAN_Q30[i];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += ARCTAN_Q30[i];
                end
            end
            c = (x + 32768) >>> 16;
            s = (y + 32768) >>> 16;
            case (q)
                0: begin de = s;  dn = c;  end
                1: begin de = c;  dn = -s; end
                2: begin de = -s; dn = -c; end
                default: begin de = -c; dn = s; end
            endcase
            if (rng < 0)
            begin
                de = -de;
                dn = -dn;
            end
        end
        east = e + de;
        north = n + dn;
        if (east > EAST_MAX)
        begin
            east = EAST_MAX;
            p.clipped = 1'b1;
        end
        else if (east < -EAST_MAX)
        begin
            east = -EAST_MAX;
            p.clipped = 1'b1;
        end
        if (north > NORTH_MAX)
        begin
            north = NORTH_MAX;
            p.clipped = 1'b1;
        end
        else if (north < -NORTH_MAX)
        begin
            north = -NORTH_MAX;
            p.clipped = 1'b1;
        end
        p.east = east[31:0];
        p.north = north[35:0];
        p.zone = zn;
        return p;
    endfunction

    // Results are checked before the word accepted at the same edge is queued.
    always @(posedge clk)
    begin
        grid_point_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("result word with no word outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (out_easting_mm !== want.east)
                    begin
                        $error("out_easting_mm: expected %0d, got %0d", want.east, out_easting_mm);
                        error_count++;
                    end
                    if (out_northing_mm !== want.north)
                    begin
                        $error("out_northing_mm: expected %0d, got %0d",
                               want.north, out_northing_mm);
                        error_count++;
                    end
                    if (out_zone !== want.zone)
                    begin
                        $error("out_zone: expected %0d, got %0d", want.zone, out_zone);
                        error_count++;
                    end
                    if (saturated !== want.clipped)
                    begin
                        $error("saturated: expected %0b, got %0b", want.clipped, saturated);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                pending_points.insert(pending_points.size(),
                                      offset_point(easting_mm, northing_mm, zone,
                                                   range_mm, bearing_mdeg));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Returns at the edge where the word was accepted.
    task automatic send_word(longint e, longint n, longint zn, longint rng, longint brg);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        easting_mm <= e[31:0];
        northing_mm <= n[35:0];
        zone <= zn[5:0];
        range_mm <= rng[27:0];
        bearing_mdeg <= brg[31:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic longint rand_east();
        return longint'($urandom_range(0, 32'd4000000000)) - EAST_MAX;
    endfunction

    function automatic longint rand_north();
        return longint'($urandom_range(0, 40000)) * 1000000
               + longint'($urandom_range(0, 999999)) - NORTH_MAX;
    endfunction

    function automatic longint rand_range();
        if ($urandom_range(0, 15) == 0)
            return 0;
        return longint'($urandom_range(0, 200000000)) - 100000000;
    endfunction

    function automatic longint rand_bearing();
        if ($urandom_range(0, 3) == 0)
            return longint'(int'($urandom));
        return longint'($urandom_range(0, 359999));
    endfunction

    task automatic test_directed();
        idle_on = 1'b1;
        send_word(0, 0, 1, 0, 0);
        send_word(123456, -7654321, 60, 0, 12345);
        send_word(1000, 2000, 5, 1000000, 0);
        send_word(1000, 2000, 5, 1000000, 90000);
        send_word(1000, 2000, 5, 1000000, 180000);
        send_word(1000, 2000, 5, 1000000, 270000);
        send_word(-555, 777, 7, 1000000, 89999);
        send_word(-555, 777, 7, 1000000, 359999);
        send_word(0, 0, 8, 99999999, 360000);
        send_word(0, 0, 9, 99999999, -1);
        send_word(0, 0, 10, RANGE_MAX, -64'sd2147483648);
        send_word(0, 0, 11, RANGE_MIN, 64'd2147483647);
        send_word(42, -42, 12, -1, 45000);
        send_word(42, -42, 13, 1, 0);
        // Offsets that push each coordinate past its limit.
        send_word(EAST_MAX - 1, 0, 14, 100000000, 90000);
        send_word(-EAST_MAX + 1, 0, 15, 100000000, 270000);
        send_word(0, NORTH_MAX - 1, 16, 100000000, 0);
        send_word(0, -NORTH_MAX + 1, 17, -100000000, 0);
        // Out-of-range coordinates clip even when the range is zero; points on the limits pass through.
        send_word(64'h7fffffff, 0, 18, 0, 0);
        send_word(-64'sd2147483648, -64'sd34359738368, 0, 0, 0);
        send_word(0, 64'h7ffffffff, 63, 5, 135000);
        send_word(EAST_MAX, NORTH_MAX, 60, 0, 0);
        send_word(-EAST_MAX, -NORTH_MAX, 1, 0, 0);
    endtask

    task automatic test_in_range_points();
        for (int i = 0; i < 700; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_word(rand_east(), rand_north(), $urandom_range(1, 60), rand_range(),
                      rand_bearing());
        end
    endtask

    // Every bit of every field, with coordinates and range well outside the nominal ranges.
    task automatic test_full_width();
        for (int i = 0; i < 450; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 2) == 0);
            send_word(longint'(int'($urandom)),
                      (longint'($urandom) << 32) | longint'($urandom),
                      $urandom_range(0, 63),
                      longint'(int'($urandom)),
                      longint'(int'($urandom)));
        end
    endtask

    task automatic test_near_limits();
        longint e, n;
        for (int i = 0; i < 500; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            e = EAST_MAX - longint'($urandom_range(0, 150000000));
            n = NORTH_MAX - longint'($urandom_range(0, 150000000));
            if ($urandom_range(0, 1))
                e = -e;
            if ($urandom_range(0, 1))
                n = -n;
            if ($urandom_range(0, 1))
                e = rand_east();
            else if ($urandom_range(0, 1))
                n = rand_north();
            send_word(e, n, $urandom_range(1, 60), rand_range(), rand_bearing());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_in_range_points();
        test_full_width();
        test_near_limits();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_points.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
